// File: rtl/bbs_pkg.sv
// Shared types and constants of the bitmap block store.
package bbs_pkg;

  localparam int BLOCK_TOTAL_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF  = 64;
  localparam int ACCESS_BYTES_DEF = 8;

  // Free-map row width in bits
  localparam int MAP_W  = 64;
  localparam int MAP_BW = 6;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_WRITE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARAM   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNALLOC = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ready;
    logic clr_step;
    logic map_rd;
    logic map_chk;
    logic map_wr;
    logic scan_next;
    logic data_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_rw;
    logic req_ok;
    logic found;
    logic scan_last;
    logic byte_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/bbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       q
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

// File: rtl/bbs_ctrl.sv
// Sequencing state machine of the bitmap block store.
module bbs_ctrl
  import bbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_MAP_RD  = 8'b0000_0100,
    S_MAP_CHK = 8'b0000_1000,
    S_MAP_WR  = 8'b0001_0000,
    S_DATA    = 8'b0010_0000,
    S_DRAIN   = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) state_next = S_MAP_RD;
      end
      S_MAP_RD: begin
        cmd.map_rd = 1'b1;
        state_next = S_MAP_CHK;
      end
      S_MAP_CHK: begin
        cmd.map_chk = 1'b1;
        if (stat.is_alloc) begin
          if (stat.found) begin
            state_next = S_MAP_WR;
          end else if (stat.scan_last) begin
            state_next = S_OUT;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_MAP_RD;
          end
        end else if (!stat.req_ok) begin
          state_next = S_OUT;
        end else if (stat.is_rw) begin
          state_next = S_DATA;
        end else begin
          state_next = S_MAP_WR;
        end
      end
      S_MAP_WR: begin
        cmd.map_wr = 1'b1;
        state_next = S_OUT;
      end
      S_DATA: begin
        cmd.data_step = 1'b1;
        if (stat.byte_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: rtl/bbs_dpath.sv
// Datapath of the bitmap block store: request registers, free map, data store.
module bbs_dpath
  import bbs_pkg::*;
#(
  parameter int BLOCK_TOTAL  = BLOCK_TOTAL_DEF,
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int ACCESS_BYTES = ACCESS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_valid,
  input  logic [95:0] in_data,
  input  logic [1:0]  in_user,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [79:0] out_data,
  output logic [1:0]  out_user
);

  localparam int RESV_RAW   = ((BLOCK_TOTAL / 8) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int RESV       = (RESV_RAW > 0) ? RESV_RAW : 1;
  localparam int DATA_BYTES = (BLOCK_TOTAL - RESV) * BLOCK_BYTES;
  localparam int DAW        = $clog2(DATA_BYTES);
  localparam int MAP_ROWS   = (BLOCK_TOTAL + MAP_W - 1) / MAP_W;
  localparam int RAW        = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  // Captured request
  mode_t        mode_r;
  logic [15:0]  id_r;
  logic [6:0]   off_r;
  logic [3:0]   cnt_r;
  logic [63:0]  wdat_r;

  // Working registers
  logic [DAW-1:0]   clr_cnt;
  logic [RAW-1:0]   scan_row;
  logic [RAW-1:0]   map_wrow;
  logic [MAP_W-1:0] map_wdata;
  logic [DAW-1:0]   base;
  logic [2:0]       idx;
  logic             rd_pend;
  logic [2:0]       rd_slot;
  logic [15:0]      res_ret;
  logic [63:0]      res_rd;
  status_t          res_st;

  // Memory ports
  logic             map_we;
  logic [RAW-1:0]   map_waddr;
  logic [MAP_W-1:0] map_wd;
  logic [RAW-1:0]   map_raddr;
  logic [MAP_W-1:0] map_q;
  logic             dat_we;
  logic [DAW-1:0]   dat_waddr;
  logic [7:0]       dat_wd;
  logic [DAW-1:0]   dat_addr;
  logic [7:0]       dat_q;

  // Decode and checks
  logic             accept;
  logic             id_ok;
  logic             cnt_ok;
  logic             range_ok;
  logic [RAW-1:0]   id_row;
  logic [MAP_BW-1:0] id_bit;
  logic             found;
  logic [MAP_BW-1:0] free_bit;
  logic [MAP_W-1:0] reset_row;
  logic [RAW+MAP_BW-1:0] rst_idx;
  logic [15:0]      alloc_id;

  assign accept   = in_valid && cmd.ready;
  assign id_ok    = ({1'b0, id_r} >= 17'(RESV)) && ({1'b0, id_r} < 17'(BLOCK_TOTAL));
  assign cnt_ok   = (cnt_r != 4'd0) && (cnt_r <= 4'(ACCESS_BYTES));
  assign range_ok = (11'(off_r) + 11'(cnt_r)) <= 11'(BLOCK_BYTES);
  assign id_row   = id_r[RAW+MAP_BW-1:MAP_BW];
  assign id_bit   = id_r[MAP_BW-1:0];
  assign alloc_id = 16'({scan_row, free_bit});

  // Find lowest clear bit of the fetched map row
  always_comb begin
    found    = 1'b0;
    free_bit = '0;
    for (int j = MAP_W - 1; j >= 0; j--) begin
      if (!map_q[j]) begin
        found    = 1'b1;
        free_bit = MAP_BW'(j);
      end
    end
  end

  // Reset pattern of the map row under the clearing sweep
  always_comb begin
    reset_row = '0;
    rst_idx   = '0;
    for (int j = 0; j < MAP_W; j++) begin
      rst_idx      = {clr_cnt[RAW-1:0], MAP_BW'(j)};
      reset_row[j] = ({1'b0, rst_idx} < (RAW+MAP_BW+1)'(RESV)) ||
                     ({1'b0, rst_idx} >= (RAW+MAP_BW+1)'(BLOCK_TOTAL));
    end
  end

  // Status to controller
  assign stat.clr_last  = (clr_cnt == DAW'(DATA_BYTES - 1));
  assign stat.is_alloc  = (mode_r == MODE_ALLOC);
  assign stat.is_rw     = (mode_r == MODE_READ) || (mode_r == MODE_WRITE);
  assign stat.req_ok    = (mode_r == MODE_RELEASE) ? id_ok : (id_ok && cnt_ok && range_ok);
  assign stat.found     = found;
  assign stat.scan_last = (scan_row == RAW'(MAP_ROWS - 1));
  assign stat.byte_last = (idx == 3'(cnt_r - 4'd1));
  assign stat.out_free  = !out_valid || out_ready;

  // Map port muxing
  assign map_we    = (cmd.clr_step && (clr_cnt < DAW'(MAP_ROWS))) || cmd.map_wr;
  assign map_waddr = cmd.clr_step ? clr_cnt[RAW-1:0] : map_wrow;
  assign map_wd    = cmd.clr_step ? reset_row : map_wdata;
  assign map_raddr = (mode_r == MODE_ALLOC) ? scan_row : id_row;

  // Data port muxing
  assign dat_addr  = base + DAW'(idx);
  assign dat_we    = cmd.clr_step || (cmd.data_step && (mode_r == MODE_WRITE));
  assign dat_waddr = cmd.clr_step ? clr_cnt : dat_addr;
  assign dat_wd    = cmd.clr_step ? 8'd0 : wdat_r[8*idx +: 8];

  bbs_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wd),
    .raddr (map_raddr),
    .q     (map_q)
  );

  bbs_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wd),
    .raddr (dat_addr),
    .q     (dat_q)
  );

  // Capture request
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_user);
      id_r   <= in_data[15:0];
      off_r  <= in_data[22:16];
      cnt_r  <= in_data[26:23];
      wdat_r <= in_data[90:27];
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step && !stat.clr_last) begin
      clr_cnt <= clr_cnt + DAW'(1);
    end
  end

  // Scan row, byte address and byte index
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_row <= '0;
      idx      <= '0;
    end else begin
      if (cmd.scan_next) scan_row <= scan_row + RAW'(1);
      if (cmd.data_step) idx <= idx + 3'd1;
    end
    if (cmd.map_rd) begin
      base <= DAW'(DAW'(id_r - 16'(RESV)) * DAW'(BLOCK_BYTES)) + DAW'(off_r);
    end
  end

  // Track read data in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.data_step && (mode_r == MODE_READ);
    end
    rd_slot <= idx;
  end

  // Build result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_ret <= '0;
      res_rd  <= '0;
      res_st  <= ST_OK;
    end else begin
      if (cmd.map_chk) begin
        if (mode_r == MODE_ALLOC) begin
          map_wrow <= scan_row;
          if (found) begin
            res_ret   <= alloc_id;
            res_st    <= ST_OK;
            map_wdata <= map_q | (MAP_W'(1) << free_bit);
          end else begin
            res_st <= ST_FULL;
          end
        end else if (!stat.req_ok) begin
          res_st <= ST_PARAM;
        end else if (mode_r == MODE_RELEASE) begin
          map_wrow  <= id_row;
          map_wdata <= map_q & ~(MAP_W'(1) << id_bit);
          res_ret   <= id_r;
          res_st    <= ST_OK;
        end else begin
          res_ret <= 16'(cnt_r);
          res_st  <= map_q[id_bit] ? ST_OK : ST_UNALLOC;
        end
      end
      if (rd_pend) begin
        res_rd[8*rd_slot +: 8] <= dat_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {res_rd, res_ret};
      out_user <= res_st;
    end
  end

endmodule

// File: rtl/bitmap_block_store.sv
// Bitmap block store: free-map allocator with a byte-addressed block store.
// Allocate scans the 64-bit free-map rows in turn until one holds a clear bit; release reads
// and rewrites one map row; read and write move byte_count bytes of the block, one byte
// per cycle. A result left waiting on m_axis_tready holds off the next item. One item at a time.
// Reset: synchronous; a clearing pass zeroes (BLOCK_TOTAL-reserved)*BLOCK_BYTES data bytes (65408).
module bitmap_block_store
  import bbs_pkg::*;
#(
  parameter int BLOCK_TOTAL  = BLOCK_TOTAL_DEF,
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int ACCESS_BYTES = ACCESS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_id[15:0], byte_offset[22:16], byte_count[26:23], write_data[90:27]
  input  logic [95:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ret_value[15:0], read_data[79:16]
  output logic [79:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  cmd_t  cmd;
  stat_t stat;

  assign s_axis_tready = cmd.ready;

  bbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbs_dpath #(
    .BLOCK_TOTAL  (BLOCK_TOTAL),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ACCESS_BYTES (ACCESS_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  // Clearing pass blocks input after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // Parameter error and full report a zero return value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_PARAM || m_axis_tuser == ST_FULL))
      |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("nonzero return value on error");

  // Commands never overlap clearing with request work
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.map_wr, cmd.data_step, cmd.ready}))
    else $error("conflicting controller commands");

endmodule
